// ===== rtl/ccct_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and tag helper functions for the chat color code translator.
// No dependencies; every other file imports this package.
package ccct_pkg;

    // Fixed widths of the payload
    localparam int CHAR_W      = 16;
    localparam int VAL_W       = 7;
    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int              CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE = 1'b1;

    // Input control codes
    localparam logic [CHAR_W-1:0] CTL_BOLD    = 16'd2;
    localparam logic [CHAR_W-1:0] CTL_COLOR   = 16'd3;
    localparam logic [CHAR_W-1:0] CTL_RESET   = 16'd15;
    localparam logic [CHAR_W-1:0] CTL_ITALIC  = 16'd22;
    localparam logic [CHAR_W-1:0] CTL_UNDER   = 16'd31;
    localparam logic [CHAR_W-1:0] CTL_PERCENT = 16'd37;
    localparam logic [CHAR_W-1:0] CTL_COMMA   = 16'd44;
    localparam logic [CHAR_W-1:0] DIGIT_BELOW = 16'd47;
    localparam logic [CHAR_W-1:0] DIGIT_ABOVE = 16'd58;

    // Output characters of the tags
    localparam logic [7:0] CH_PERCENT = 8'd37;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_B_LO    = "b";
    localparam logic [7:0] CH_B_UP    = "B";
    localparam logic [7:0] CH_C_LO    = "c";
    localparam logic [7:0] CH_C_UP    = "C";
    localparam logic [7:0] CH_F_LO    = "f";
    localparam logic [7:0] CH_F_UP    = "F";
    localparam logic [7:0] CH_I_LO    = "i";
    localparam logic [7:0] CH_I_UP    = "I";
    localparam logic [7:0] CH_U_LO    = "u";
    localparam logic [7:0] CH_U_UP    = "U";
    localparam logic [7:0] CH_R_LO    = "r";

    // Color value that is kept as is and gives the upper-case tag
    localparam logic [VAL_W-1:0] COLOR_KEEP = 7'd99;

    // Color parse phase
    typedef enum logic [2:0] {
        PH_TEXT  = 3'd0,
        PH_COLOR = 3'd1,
        PH_FORE1 = 3'd2,
        PH_FORE2 = 3'd3,
        PH_COMMA = 3'd4,
        PH_BACK1 = 3'd5
    } phase_t;

    // Color output segment ahead of or behind the text part
    typedef enum logic [2:0] {
        SEG_NONE       = 3'd0,
        SEG_CF         = 3'd1,
        SEG_FORE       = 3'd2,
        SEG_FORE_COMMA = 3'd3,
        SEG_FORE_BACK  = 3'd4
    } seg_kind_t;

    // Text part of an item
    typedef enum logic [1:0] {
        MID_NONE = 2'd0,
        MID_CHAR = 2'd1,
        MID_PCT  = 2'd2,
        MID_TAG  = 2'd3
    } mid_kind_t;

    // Classified item, front to back
    typedef struct packed {
        seg_kind_t         pre_kind;
        mid_kind_t         mid_kind;
        logic [CHAR_W-1:0] mid_char;
        seg_kind_t         flush_kind;
        logic [VAL_W-1:0]  fore_val;
        logic [VAL_W-1:0]  back_val;
    } entry_t;

    // Back-end status
    typedef struct packed {
        logic pop;
        logic emit;
    } back_stat_t;

    // Length of one color tag
    function automatic logic [2:0] tag_len(logic [VAL_W-1:0] v, logic strip);
        logic [2:0] len;
        if (strip) begin
            len = 3'd0;
        end else if (v == COLOR_KEEP) begin
            len = 3'd2;
        end else begin
            len = 3'd4;
        end
        return len;
    endfunction

    // Length of a color segment
    function automatic logic [CNT_W-1:0] seg_len(seg_kind_t k, logic [2:0] lf, logic [2:0] lb,
                                                 logic strip);
        logic [CNT_W-1:0] len;
        unique case (k)
            SEG_CF:         len = strip ? 4'd0 : 4'd4;
            SEG_FORE:       len = {1'b0, lf};
            SEG_FORE_COMMA: len = {1'b0, lf} + 4'd1;
            SEG_FORE_BACK:  len = {1'b0, lf} + {1'b0, lb};
            default:        len = 4'd0;
        endcase
        return len;
    endfunction

    // One character of a color tag: %xNN, or %X for the kept value
    function automatic logic [7:0] tag_unit(logic [VAL_W-1:0] v, logic [1:0] o,
                                            logic [7:0] lo, logic [7:0] up);
        logic [3:0] m;
        logic [3:0] ones;
        logic       tens;
        logic [7:0] ch;
        m    = v[3:0];
        tens = (m > 4'd9);
        ones = tens ? (m - 4'd10) : m;
        case (o)
            2'd0:    ch = CH_PERCENT;
            2'd1:    ch = (v == COLOR_KEEP) ? up : lo;
            2'd2:    ch = CH_ZERO + {7'b0, tens};
            default: ch = CH_ZERO + {4'b0, ones};
        endcase
        return ch;
    endfunction

    // One character of a color segment at offset o
    function automatic logic [7:0] seg_unit(seg_kind_t k, logic [CNT_W-1:0] o,
                                            logic [VAL_W-1:0] fv, logic [VAL_W-1:0] bv,
                                            logic [2:0] lf);
        logic [CNT_W-1:0] ob;
        logic [7:0]       ch;
        ob = o - {1'b0, lf};
        if (k == SEG_CF) begin
            case (o[1:0])
                2'd0:    ch = CH_PERCENT;
                2'd1:    ch = CH_C_UP;
                2'd2:    ch = CH_PERCENT;
                default: ch = CH_F_UP;
            endcase
        end else if (o < {1'b0, lf}) begin
            ch = tag_unit(fv, o[1:0], CH_C_LO, CH_C_UP);
        end else if (k == SEG_FORE_COMMA) begin
            ch = CH_COMMA;
        end else begin
            ch = tag_unit(bv, ob[1:0], CH_F_LO, CH_F_UP);
        end
        return ch;
    endfunction

endpackage

// ===== rtl/chat_color_code_translator_top.sv =====
`timescale 1ns / 1ps
// Top level of the chat color code translator: configuration registers, front end,
// item queue and back end. Uses ccct_pkg, ccct_front, ccct_queue and ccct_back.
//
// Translates a stream of chat characters into text with percent tags for bold, italics,
// underline, reset and color controls. An input item is taken in every cycle while the
// four-entry queue between the front end and the back end has room; the front end
// classifies it in the cycle it arrives. The back end drives one output character per
// cycle while m_tready accepts them, and an item that gives no results is still retired
// by it; the sustained rate is set by that single output port. An item gives up to twelve
// results; m_tlast marks the last one of an item. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; the block does not enforce this.
module chat_color_code_translator_top import ccct_pkg::*; #(
    parameter int CHAR_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [15:0] in_char
    input  logic                 s_tlast,   // in_last
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [15:0] out_char
    output logic                 m_tlast,   // run_last
    // Configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_wdata
);

    logic       strip_reg;
    logic       double_reg;
    logic       push;
    logic       q_full;
    logic       q_valid;
    entry_t     fe_entry;
    entry_t     q_head;
    back_stat_t bk_stat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_reg  <= 1'b0;
            double_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STRIP:  strip_reg  <= cfg_wdata;
                REG_DOUBLE: double_reg <= cfg_wdata;
                default:    strip_reg  <= strip_reg;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    ccct_front #(
        .CHAR_BITS (CHAR_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .in_char (s_tdata),
        .in_last (s_tlast),
        .entry   (fe_entry)
    );

    ccct_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (fe_entry),
        .pop      (bk_stat.pop),
        .rd_entry (q_head),
        .rd_valid (q_valid),
        .full     (q_full)
    );

    ccct_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .strip_tags     (strip_reg),
        .double_percent (double_reg),
        .head           (q_head),
        .head_valid     (q_valid),
        .stat           (bk_stat),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

    // The back end only retires an item that is in the queue
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.pop |-> q_valid)
        else $error("queue popped while empty");

    // A stalled output character is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !bk_stat.emit)
        else $error("output register loaded while stalled");

    // A character loaded into the output register is presented next cycle
    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.emit |=> m_tvalid)
        else $error("loaded character not presented");

endmodule

// ===== rtl/ccct_front.sv =====
`timescale 1ns / 1ps
// Front end: tracks formatting flags and the color parse phase, and classifies each item
// into a queue entry (color segment, text part, end-of-message segment). Uses ccct_pkg.
module ccct_front import ccct_pkg::*; #(
    parameter int CHAR_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_last,
    output entry_t            entry
);

    localparam logic [CHAR_W-1:0] CHAR_MASK = CHAR_W'((32'd1 << CHAR_BITS) - 32'd1);

    phase_t           phase_reg, phase_next;
    logic             bold_reg, bold_next;
    logic             italic_reg, italic_next;
    logic             under_reg, under_next;
    logic [VAL_W-1:0] fore_reg, fore_next;
    logic [3:0]       back_reg, back_next;

    logic [CHAR_W-1:0] c;
    logic              is_digit;
    logic [3:0]        dval;
    logic [VAL_W-1:0]  fore_x10;
    logic [VAL_W-1:0]  back_x10;
    logic              do_plain;

    // Character decode
    assign c        = in_char & CHAR_MASK;
    assign is_digit = (c > DIGIT_BELOW) && (c < DIGIT_ABOVE);
    assign dval     = c[3:0];
    assign fore_x10 = (fore_reg << 3) + (fore_reg << 1);
    assign back_x10 = ({3'b0, back_reg} << 3) + ({3'b0, back_reg} << 1);

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_TEXT;
            bold_reg   <= 1'b0;
            italic_reg <= 1'b0;
            under_reg  <= 1'b0;
            fore_reg   <= '0;
            back_reg   <= '0;
        end else if (push) begin
            phase_reg  <= phase_next;
            bold_reg   <= bold_next;
            italic_reg <= italic_next;
            under_reg  <= under_next;
            fore_reg   <= fore_next;
            back_reg   <= back_next;
        end
    end

    // Classification and next state
    always_comb begin
        phase_next  = phase_reg;
        bold_next   = bold_reg;
        italic_next = italic_reg;
        under_next  = under_reg;
        fore_next   = fore_reg;
        back_next   = back_reg;
        do_plain    = 1'b0;

        entry.pre_kind   = SEG_NONE;
        entry.mid_kind   = MID_NONE;
        entry.mid_char   = c;
        entry.flush_kind = SEG_NONE;
        entry.fore_val   = fore_reg;
        entry.back_val   = {3'b0, back_reg};

        // Color lookahead
        unique case (phase_reg)
            PH_COLOR: begin
                if (is_digit) begin
                    fore_next  = {3'b0, dval};
                    phase_next = PH_FORE1;
                end else begin
                    entry.pre_kind = SEG_CF;
                    phase_next     = PH_TEXT;
                    do_plain       = 1'b1;
                end
            end
            PH_FORE1: begin
                if (is_digit) begin
                    fore_next  = fore_x10 + {3'b0, dval};
                    phase_next = PH_FORE2;
                end else if (c == CTL_COMMA) begin
                    phase_next = PH_COMMA;
                end else begin
                    entry.pre_kind = SEG_FORE;
                    phase_next     = PH_TEXT;
                    do_plain       = 1'b1;
                end
            end
            PH_FORE2: begin
                if (c == CTL_COMMA) begin
                    phase_next = PH_COMMA;
                end else begin
                    entry.pre_kind = SEG_FORE;
                    phase_next     = PH_TEXT;
                    do_plain       = 1'b1;
                end
            end
            PH_COMMA: begin
                if (is_digit) begin
                    back_next  = dval;
                    phase_next = PH_BACK1;
                end else begin
                    entry.pre_kind = SEG_FORE_COMMA;
                    phase_next     = PH_TEXT;
                    do_plain       = 1'b1;
                end
            end
            PH_BACK1: begin
                entry.pre_kind = SEG_FORE_BACK;
                phase_next     = PH_TEXT;
                if (is_digit) begin
                    entry.back_val = back_x10 + {3'b0, dval};
                end else begin
                    do_plain = 1'b1;
                end
            end
            default: begin
                phase_next = PH_TEXT;
                do_plain   = 1'b1;
            end
        endcase

        // Ordinary text and formatting controls
        if (do_plain) begin
            unique case (c)
                CTL_PERCENT: entry.mid_kind = MID_PCT;
                CTL_BOLD: begin
                    entry.mid_kind = MID_TAG;
                    entry.mid_char = {8'h00, bold_reg ? CH_B_UP : CH_B_LO};
                    bold_next      = !bold_reg;
                end
                CTL_RESET: begin
                    entry.mid_kind = MID_TAG;
                    entry.mid_char = {8'h00, CH_R_LO};
                    bold_next      = 1'b0;
                    under_next     = 1'b0;
                end
                CTL_ITALIC: begin
                    entry.mid_kind = MID_TAG;
                    entry.mid_char = {8'h00, italic_reg ? CH_I_UP : CH_I_LO};
                    italic_next    = !italic_reg;
                end
                CTL_UNDER: begin
                    entry.mid_kind = MID_TAG;
                    entry.mid_char = {8'h00, under_reg ? CH_U_UP : CH_U_LO};
                    under_next     = !under_reg;
                end
                CTL_COLOR: phase_next = PH_COLOR;
                default:   entry.mid_kind = MID_CHAR;
            endcase
        end

        // End of message: flush pending color and clear everything
        if (in_last) begin
            unique case (phase_next) inside
                PH_COLOR: entry.flush_kind = SEG_CF;
                PH_FORE1, PH_FORE2: begin
                    entry.flush_kind = SEG_FORE;
                    entry.fore_val   = fore_next;
                end
                PH_COMMA: begin
                    entry.flush_kind = SEG_FORE_COMMA;
                    entry.fore_val   = fore_next;
                end
                PH_BACK1: begin
                    entry.flush_kind = SEG_FORE_BACK;
                    entry.fore_val   = fore_next;
                    entry.back_val   = {3'b0, back_next};
                end
                default: entry.flush_kind = SEG_NONE;
            endcase
            phase_next  = PH_TEXT;
            bold_next   = 1'b0;
            italic_next = 1'b0;
            under_next  = 1'b0;
            fore_next   = '0;
            back_next   = '0;
        end
    end

endmodule

// ===== rtl/ccct_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified items between the front and back ends.
// Uses entry_t and depth constants from ccct_pkg.
module ccct_queue import ccct_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t wr_entry,
    input  logic   pop,
    output entry_t rd_entry,
    output logic   rd_valid,
    output logic   full
);

    entry_t                 slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;

    assign rd_valid = (count_reg != '0);
    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign rd_entry = slots_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/ccct_back.sv =====
`timescale 1ns / 1ps
// Back end: expands the queue head into output characters, one per cycle while m_tready
// accepts them, into an output register. Uses the tag helper functions and types of ccct_pkg.
module ccct_back import ccct_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              strip_tags,
    input  logic              double_percent,
    input  entry_t            head,
    input  logic              head_valid,
    output back_stat_t        stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,
    output logic              m_tlast
);

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;

    logic [2:0]        len_fore;
    logic [2:0]        len_back;
    logic [CNT_W-1:0]  len_pre;
    logic [CNT_W-1:0]  len_mid;
    logic [CNT_W-1:0]  len_flush;
    logic [CNT_W-1:0]  len_total;
    logic [CNT_W-1:0]  pre_mid;
    logic [CNT_W-1:0]  off_mid;
    logic [CNT_W-1:0]  off_flush;
    logic [CHAR_W-1:0] unit;
    logic              last_unit;
    logic              load;
    logic              pop;

    // Segment lengths of the head item
    always_comb begin
        len_fore  = tag_len(head.fore_val, strip_tags);
        len_back  = tag_len(head.back_val, strip_tags);
        len_pre   = seg_len(head.pre_kind, len_fore, len_back, strip_tags);
        len_flush = seg_len(head.flush_kind, len_fore, len_back, strip_tags);
        case (head.mid_kind)
            MID_CHAR: len_mid = 4'd1;
            MID_PCT:  len_mid = double_percent ? 4'd2 : 4'd1;
            MID_TAG:  len_mid = strip_tags ? 4'd0 : 4'd2;
            default:  len_mid = 4'd0;
        endcase
        pre_mid   = len_pre + len_mid;
        len_total = pre_mid + len_flush;
        off_mid   = idx_reg - len_pre;
        off_flush = idx_reg - pre_mid;
    end

    // Character at the current position
    always_comb begin
        if (idx_reg < len_pre) begin
            unit = {8'h00, seg_unit(head.pre_kind, idx_reg, head.fore_val, head.back_val,
                                    len_fore)};
        end else if (idx_reg < pre_mid) begin
            case (head.mid_kind)
                MID_CHAR: unit = head.mid_char;
                MID_TAG:  unit = (off_mid == '0) ? {8'h00, CH_PERCENT} : head.mid_char;
                default:  unit = {8'h00, CH_PERCENT};
            endcase
        end else begin
            unit = {8'h00, seg_unit(head.flush_kind, off_flush, head.fore_val, head.back_val,
                                    len_fore)};
        end
    end

    // Emit and pop control
    always_comb begin
        last_unit      = (idx_reg == len_total - 4'd1);
        load           = head_valid && (len_total != '0) && (!out_valid_reg || m_tready);
        pop            = head_valid && ((len_total == '0) || (load && last_unit));
        idx_next       = pop ? '0 : (load ? idx_reg + 4'd1 : idx_reg);
        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            out_char_reg <= unit;
            out_last_reg <= last_unit;
        end
    end

    assign stat.pop  = pop;
    assign stat.emit = load;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_char_reg;
    assign m_tlast   = out_last_reg;

endmodule
